@@ hdl/pid_servo_angle_controller_core_assert.svh @@
// Assertion macros shared by the PID servo controller RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef PID_SERVO_ANGLE_CONTROLLER_CORE_ASSERT_SVH
`define PID_SERVO_ANGLE_CONTROLLER_CORE_ASSERT_SVH

// Property checked every clock outside reset.
`define PSAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define PSAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/psac_pkg.sv @@
// Package for the PID servo angle controller: widths, config struct,
// microcode control word and the microprogram ROM. No dependencies.
package psac_pkg;

    localparam int ERR_W   = 15;   // error after deadband, signed Q7.8
    localparam int DIFF_W  = 17;   // error difference
    localparam int ACC_W   = 34;   // integral accumulator, signed Q.24
    localparam int ACCT_W  = 35;   // accumulator before clamp
    localparam int MA_W    = 34;   // multiplier operand A, signed
    localparam int MB_W    = 18;   // multiplier operand B, signed
    localparam int PROD_W  = MA_W + MB_W;
    localparam int SUM_W   = 61;   // angle sum, signed Q.32
    localparam int FRAC_Q  = 32;
    localparam int STEP_W  = 4;

    localparam logic signed [SUM_W-1:0] SUM_CENTER = 61'sd386547056640; // 90.0
    localparam logic signed [SUM_W-1:0] SUM_MAX    = 61'sd773094113280; // 180.0
    localparam logic [7:0]              ANGLE_MAX  = 8'd180;
    localparam logic [10:0]             PW_MIN     = 11'd250;
    // ceil(2^16 / 9): (50*angle*RECIP9) >> 16 == (1000*angle) / 180 for angle <= 180
    localparam logic signed [MB_W-1:0]  RECIP9     = 18'sd7282;

    typedef struct packed {
        logic [13:0] setpoint;
        logic [13:0] deadband;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [15:0] period_frac;
        logic [9:0]  update_rate;
        logic [15:0] integ_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_SETPOINT    = 3'd0,
        REG_DEADBAND    = 3'd1,
        REG_PROP_GAIN   = 3'd2,
        REG_INTEG_GAIN  = 3'd3,
        REG_DERIV_GAIN  = 3'd4,
        REG_PERIOD_FRAC = 3'd5,
        REG_UPDATE_RATE = 3'd6,
        REG_INTEG_LIMIT = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_JUMP
    } t_seq;

    typedef enum logic [2:0] {
        A_ERR,
        A_DIFF,
        A_PROD,
        A_ACC,
        A_ANG50
    } t_a_sel;

    typedef enum logic [2:0] {
        B_PERIOD,
        B_PGAIN,
        B_RATE,
        B_DGAIN,
        B_IGAIN,
        B_RECIP
    } t_b_sel;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_ERR,
        ALU_DB,
        ALU_DIFF,
        ALU_ACCADD,
        ALU_ACCCLP,
        ALU_SUM16,
        ALU_SUM,
        ALU_SAT,
        ALU_PW
    } t_alu_op;

    typedef struct packed {
        t_seq              seq;
        logic [STEP_W-1:0] target;
        logic              mul_en;
        t_a_sel            a_sel;
        t_b_sel            b_sel;
        t_alu_op           alu;
    } t_ctrl;

    localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ERR   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DB    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIFF  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ACCA  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ACCC  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DMUL  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SUMD  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SUMI  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SAT   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_PWMUL = 4'd10;
    localparam logic [STEP_W-1:0] STEP_PW    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_OUT   = 4'd12;

    // Microprogram. Multiplier result is registered in the product register,
    // so each ALU op that uses the product consumes the one issued the step before.
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{seq: SEQ_NEXT, target: STEP_WAIT, mul_en: 1'b0,
              a_sel: A_ERR, b_sel: B_PERIOD, alu: ALU_NOP};
        unique case (step)
            STEP_WAIT: begin
                w.seq = SEQ_WAIT_IN;
            end
            STEP_ERR: begin
                w.alu = ALU_ERR;
            end
            STEP_DB: begin
                w.alu = ALU_DB;
            end
            STEP_DIFF: begin
                w.alu = ALU_DIFF;
                w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_PERIOD;
            end
            STEP_ACCA: begin
                w.alu = ALU_ACCADD;
                w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_PGAIN;
            end
            STEP_ACCC: begin
                w.alu = ALU_ACCCLP;
                w.mul_en = 1'b1; w.a_sel = A_DIFF; w.b_sel = B_RATE;
            end
            STEP_DMUL: begin
                w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_DGAIN;
            end
            STEP_SUMD: begin
                w.alu = ALU_SUM16;
                w.mul_en = 1'b1; w.a_sel = A_ACC; w.b_sel = B_IGAIN;
            end
            STEP_SUMI: begin
                w.alu = ALU_SUM;
            end
            STEP_SAT: begin
                w.alu = ALU_SAT;
            end
            STEP_PWMUL: begin
                w.mul_en = 1'b1; w.a_sel = A_ANG50; w.b_sel = B_RECIP;
            end
            STEP_PW: begin
                w.alu = ALU_PW;
            end
            STEP_OUT: begin
                w.seq = SEQ_WAIT_OUT;
                w.target = STEP_WAIT;
            end
            default: begin
                w.seq = SEQ_JUMP;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/psac_datapath.sv @@
// Datapath of the PID servo controller: one shared 34x18 signed multiplier,
// error/integral/sum registers and the ALU ops. Driven by psac_pkg::t_ctrl.
module psac_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psac_pkg::t_ctrl   i_ctrl,
    input  psac_pkg::t_cfg    i_cfg,
    input  logic              i_load,
    input  logic [13:0]       i_meas,
    output logic [7:0]        o_angle,
    output logic [10:0]       o_pw,
    output logic              o_clamped
);

    localparam int ErrW  = psac_pkg::ERR_W;
    localparam int DiffW = psac_pkg::DIFF_W;
    localparam int AccW  = psac_pkg::ACC_W;
    localparam int AcctW = psac_pkg::ACCT_W;
    localparam int MaW   = psac_pkg::MA_W;
    localparam int MbW   = psac_pkg::MB_W;
    localparam int ProdW = psac_pkg::PROD_W;
    localparam int SumW  = psac_pkg::SUM_W;
    localparam int FracQ = psac_pkg::FRAC_Q;

    logic [13:0]              r_meas;
    logic signed [ErrW-1:0]   r_err;
    logic signed [ErrW-1:0]   r_last;
    logic signed [DiffW-1:0]  r_diff;
    logic signed [AccW-1:0]   r_acc;
    logic signed [AcctW-1:0]  r_acct;
    logic signed [ProdW-1:0]  r_prod;
    logic signed [SumW-1:0]   r_sum;
    logic [7:0]               r_angle;
    logic [10:0]              r_pw;
    logic                     r_clamped;

    logic signed [MaW-1:0]    w_a;
    logic signed [MbW-1:0]    w_b;
    logic [13:0]              w_ang50;
    logic [ErrW-1:0]          w_mag;
    logic signed [AcctW-1:0]  w_lim;
    logic signed [AcctW-1:0]  w_neg_lim;
    logic signed [SumW-1:0]   w_prod_ext;
    logic signed [SumW-1:0]   w_prod_sh16;

    always_comb begin
        w_ang50 = {1'b0, r_angle, 5'b0} + {2'b0, r_angle, 4'b0} + {5'b0, r_angle, 1'b0};
        unique case (i_ctrl.a_sel)
            psac_pkg::A_ERR:   w_a = MaW'(r_err);
            psac_pkg::A_DIFF:  w_a = MaW'(r_diff);
            psac_pkg::A_PROD:  w_a = r_prod[MaW-1:0];
            psac_pkg::A_ACC:   w_a = MaW'(r_acc);
            psac_pkg::A_ANG50: w_a = MaW'($signed({1'b0, w_ang50}));
            default:           w_a = '0;
        endcase
        unique case (i_ctrl.b_sel)
            psac_pkg::B_PERIOD: w_b = $signed({2'b00, i_cfg.period_frac});
            psac_pkg::B_PGAIN:  w_b = $signed({2'b00, i_cfg.prop_gain});
            psac_pkg::B_RATE:   w_b = $signed({8'b0, i_cfg.update_rate});
            psac_pkg::B_DGAIN:  w_b = $signed({2'b00, i_cfg.deriv_gain});
            psac_pkg::B_IGAIN:  w_b = $signed({2'b00, i_cfg.integ_gain});
            psac_pkg::B_RECIP:  w_b = psac_pkg::RECIP9;
            default:            w_b = '0;
        endcase
        w_mag       = r_err[ErrW-1] ? ErrW'(-r_err) : ErrW'(r_err);
        w_lim       = $signed({3'b000, i_cfg.integ_limit, 16'h0000});
        w_neg_lim   = -w_lim;
        w_prod_ext  = SumW'(r_prod);
        w_prod_sh16 = w_prod_ext <<< 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_meas <= i_meas;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_a * w_b;
        end
        unique case (i_ctrl.alu)
            psac_pkg::ALU_ERR: begin
                r_err <= $signed({1'b0, r_meas}) - $signed({1'b0, i_cfg.setpoint});
            end
            psac_pkg::ALU_DB: begin
                if (w_mag < {1'b0, i_cfg.deadband}) begin
                    r_err <= '0;
                end
            end
            psac_pkg::ALU_ACCADD: begin
                r_acct <= AcctW'(r_acc) + $signed(r_prod[AcctW-1:0]);
            end
            psac_pkg::ALU_ACCCLP: begin
                // product register holds the P term here
                r_sum <= psac_pkg::SUM_CENTER + w_prod_sh16;
            end
            psac_pkg::ALU_SUM16: begin
                r_sum <= r_sum + w_prod_sh16;
            end
            psac_pkg::ALU_SUM: begin
                r_sum <= r_sum + w_prod_ext;
            end
            psac_pkg::ALU_SAT: begin
                if (r_sum[SumW-1]) begin
                    r_angle   <= '0;
                    r_clamped <= 1'b1;
                end else if (r_sum > psac_pkg::SUM_MAX) begin
                    r_angle   <= psac_pkg::ANGLE_MAX;
                    r_clamped <= 1'b1;
                end else begin
                    r_angle   <= r_sum[FracQ+7:FracQ];
                    r_clamped <= 1'b0;
                end
            end
            psac_pkg::ALU_PW: begin
                r_pw <= psac_pkg::PW_MIN + {1'b0, r_prod[25:16]};
            end
            default: begin
            end
        endcase
    end

    // controller state: derivative history and integral, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_diff <= '0;
            r_acc  <= '0;
        end else begin
            if (i_ctrl.alu == psac_pkg::ALU_DIFF) begin
                r_diff <= DiffW'(r_err) - DiffW'(r_last);
                r_last <= r_err;
            end
            // anti-windup clamp
            if (i_ctrl.alu == psac_pkg::ALU_ACCCLP) begin
                if (r_acct > w_lim) begin
                    r_acc <= w_lim[AccW-1:0];
                end else if (r_acct < w_neg_lim) begin
                    r_acc <= w_neg_lim[AccW-1:0];
                end else begin
                    r_acc <= r_acct[AccW-1:0];
                end
            end
        end
    end

    assign o_angle   = r_angle;
    assign o_pw      = r_pw;
    assign o_clamped = r_clamped;

endmodule

@@ hdl/pid_servo_angle_controller_core.sv @@
// Top level of the PID servo angle controller: config registers, microcode
// step counter, stream handshakes and output register.
// Depends on psac_pkg, psac_datapath and pid_servo_angle_controller_core_assert.svh.
//
// One measured distance in, one servo command out. A 13-step microprogram
// in psac_pkg drives a datapath with a single shared 34x18 multiplier
// (used six times per item); an item accepted at step 0 is loaded into the
// output register at the final step, and the next item is taken at step 0
// again as long as the output register drains. The result waits in its own
// register, so the core works on the next item meanwhile.
// Configuration is written through i_cfg_*; the user must write it only while no item is in flight (not enforced).
module pid_servo_angle_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [13:0] measured_dist
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] servo_angle, [18:8] pulse_ticks
    output logic        m_axis_tuser    // [0] angle_clamped
);

    psac_pkg::t_cfg                     r_cfg;
    logic [psac_pkg::STEP_W-1:0]        r_step;
    logic [psac_pkg::STEP_W-1:0]        n_step;
    psac_pkg::t_ctrl                    w_ctrl;
    logic                               w_in_acc;
    logic                               w_out_free;
    logic                               w_out_load;
    logic                               r_out_valid;
    logic [7:0]                         r_out_angle;
    logic [10:0]                        r_out_pw;
    logic                               r_out_clamped;
    logic [7:0]                         w_angle;
    logic [10:0]                        w_pw;
    logic                               w_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint    <= 14'd5120;
            r_cfg.deadband    <= 14'd512;
            r_cfg.prop_gain   <= 16'd2048;
            r_cfg.integ_gain  <= 16'd205;
            r_cfg.deriv_gain  <= 16'd307;
            r_cfg.period_frac <= 16'd3277;
            r_cfg.update_rate <= 10'd20;
            r_cfg.integ_limit <= 16'd12800;
        end else if (i_cfg_we) begin
            unique case (psac_pkg::t_reg_idx'(i_cfg_addr))
                psac_pkg::REG_SETPOINT:    r_cfg.setpoint    <= i_cfg_wdata[13:0];
                psac_pkg::REG_DEADBAND:    r_cfg.deadband    <= i_cfg_wdata[13:0];
                psac_pkg::REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_wdata;
                psac_pkg::REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_wdata;
                psac_pkg::REG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg_wdata;
                psac_pkg::REG_PERIOD_FRAC: r_cfg.period_frac <= i_cfg_wdata;
                psac_pkg::REG_UPDATE_RATE: r_cfg.update_rate <= i_cfg_wdata[9:0];
                psac_pkg::REG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_ctrl        = psac_pkg::ucode(r_step);
    // no item is taken while reset is held
    assign s_axis_tready = i_rst_n & (w_ctrl.seq == psac_pkg::SEQ_WAIT_IN);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign w_out_load    = (w_ctrl.seq == psac_pkg::SEQ_WAIT_OUT) & w_out_free;

    always_comb begin
        unique case (w_ctrl.seq)
            psac_pkg::SEQ_NEXT:     n_step = r_step + psac_pkg::STEP_W'(1);
            psac_pkg::SEQ_WAIT_IN:  n_step = w_in_acc ? r_step + psac_pkg::STEP_W'(1) : r_step;
            psac_pkg::SEQ_WAIT_OUT: n_step = w_out_free ? w_ctrl.target : r_step;
            psac_pkg::SEQ_JUMP:     n_step = w_ctrl.target;
            default:                n_step = psac_pkg::STEP_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= psac_pkg::STEP_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_angle   <= w_angle;
            r_out_pw      <= w_pw;
            r_out_clamped <= w_clamped;
        end
    end

    psac_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_cfg     (r_cfg),
        .i_load    (w_in_acc),
        .i_meas    (s_axis_tdata[13:0]),
        .o_angle   (w_angle),
        .o_pw      (w_pw),
        .o_clamped (w_clamped)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_pw, r_out_angle};
    assign m_axis_tuser  = r_out_clamped;

`include "pid_servo_angle_controller_core_assert.svh"

    `PSAC_ASSERT(a_step_range, (r_step <= psac_pkg::STEP_OUT), "step counter out of program")
    `PSAC_ASSERT_NEXT(a_accept_starts, w_in_acc, (r_step == psac_pkg::STEP_ERR), "item not started")
    `PSAC_ASSERT(a_out_from_last, ($rose(m_axis_tvalid) |-> $past(r_step == psac_pkg::STEP_OUT)), "result not from final step")
    `PSAC_ASSERT(a_out_range, (m_axis_tvalid |-> (r_out_angle <= 8'd180 && r_out_pw >= 11'd250 && r_out_pw <= 11'd1250)), "result out of range")

endmodule
